// ===== design/grid_ray_obstacle_cast_assert.svh =====
// assertion macros for the ray caster top level
`ifndef GRID_RAY_OBSTACLE_CAST_ASSERT_SVH
`define GRID_RAY_OBSTACLE_CAST_ASSERT_SVH
`ifndef SYNTHESIS
`define GRO_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define GRO_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define GRO_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define GRO_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== design/gro_pkg.sv =====
// shared types, constants and helpers of the ray caster
package gro_pkg;

    localparam int MAP_DIM = 256;
    localparam int MAP_AW  = $clog2(MAP_DIM);
    localparam int CELL_W  = 13;
    localparam int LIM_W   = 9;
    localparam int RAD_W   = 26;
    localparam int ROOT_W  = 13;
    localparam int RANGE_W = 14;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic signed [RANGE_W-1:0] RANGE_NO_HIT = -14'sd16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_RD,
        S_HIT,
        S_SQX,
        S_SQY,
        S_ROOT_GO,
        S_ROOT,
        S_DONE
    } state_t;

    // q.4 to cell: add one half, truncate toward zero
    function automatic logic signed [CELL_W-1:0] to_cell(input logic signed [15:0] v);
        logic signed [16:0] t;
        logic signed [17:0] u;
        t = {v[15], v} + 17'sd8;
        u = t[16] ? ({t[16], t} + 18'sd15) : {t[16], t};
        return u[16:4];
    endfunction

endpackage

// ===== design/gro_map_ram.sv =====
// occupancy grid memory, one bit per cell, registered read
module gro_map_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [2*gro_pkg::MAP_AW-1:0] wr_addr,
    input  logic                      wr_data,
    input  logic                      rd_en,
    input  logic [2*gro_pkg::MAP_AW-1:0] rd_addr,
    output logic                      rd_data
);

    logic mem [gro_pkg::MAP_DIM*gro_pkg::MAP_DIM];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/gro_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle, rounded to nearest
module gro_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gro_pkg::RAD_W-1:0]     radicand,
    output logic                          done,
    output logic [gro_pkg::ROOT_W-1:0]    root
);

    logic [gro_pkg::RAD_W-1:0] rem_reg, rem_next;
    logic [gro_pkg::RAD_W-1:0] res_reg, res_next;
    logic [gro_pkg::RAD_W-1:0] bit_reg, bit_next;
    logic                      done_reg, done_next;
    logic [gro_pkg::RAD_W-1:0] trial;
    logic [gro_pkg::RAD_W-1:0] rounded;

    assign trial = res_reg + bit_reg;

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = radicand;
            res_next = '0;
            bit_next = {2'b01, {(gro_pkg::RAD_W-2){1'b0}}};
        end else if (bit_reg != '0) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            done_next = (bit_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign rounded = (rem_reg > res_reg) ? res_reg + 1'b1 : res_reg;
    assign root    = rounded[gro_pkg::ROOT_W-1:0];
    assign done    = done_reg;

endmodule

// ===== design/grid_ray_obstacle_cast.sv =====
// ray caster over a one-bit occupancy grid, top level
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+------------------------------------------
// s_       | in        | s_tvalid / s_tready | s_tuser action, s_tdata cell and ray fields
// m_       | out       | m_tvalid / m_tready | m_tdata hit, range_q4
// cfg_     | in        | cfg_wr_en           | cfg_addr register index, cfg_wdata value
//
// a write transfer updates the grid and produces nothing
// a cast runs setup, then one grid memory read per visited cell, and on a hit
// squaring and the 13-step square root unit
// reset (aresetn low, synchronous) clears sequencer and m_tvalid, map size goes to 256
// the next transfer is taken while a result still waits on m_
`include "grid_ray_obstacle_cast_assert.svh"
module grid_ray_obstacle_cast (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_x[7:0], cell_y[15:8], cell_value[16], start_x[32:17], start_y[48:33],
    // end_x[64:49], end_y[80:65], zero fill
    input  logic [87:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0], range_q4[14:1], zero fill
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_wdata
);

    localparam int CW = gro_pkg::CELL_W;
    localparam int LW = gro_pkg::LIM_W;
    localparam int AW = gro_pkg::MAP_AW;

    // configuration
    logic [LW-1:0] map_width_reg, map_height_reg;
    logic [LW-1:0] lim_x, lim_y;

    // sequencer
    gro_pkg::state_t state_reg, state_next;

    // cast operands, cells
    logic signed [CW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    // walk in major/minor axis form
    logic                 ma_reg, ma_next;
    logic                 negmaj_reg, negmaj_next, negmin_reg, negmin_next;
    logic signed [CW-1:0] pmaj_reg, pmaj_next, pmin_reg, pmin_next;
    logic signed [CW-1:0] prmaj_reg, prmaj_next, prmin_reg, prmin_next;
    logic signed [CW-1:0] stmaj_reg, stmaj_next, stmin_reg, stmin_next;
    logic signed [CW-1:0] endmaj_reg, endmaj_next, bound_reg, bound_next;
    logic        [CW-1:0] dmaj_reg, dmaj_next, dmin_reg, dmin_next;
    logic signed [CW:0]   err_reg, err_next;
    logic        [LW-1:0] limmin_reg, limmin_next;
    logic        [16:0]   acc_reg, acc_next;

    // result
    logic                             res_hit_reg, res_hit_next;
    logic signed [gro_pkg::RANGE_W-1:0] res_range_reg, res_range_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [15:0]                      m_tdata_reg, m_tdata_next;

    // handshake
    logic s_xfer, wr_xfer, cast_xfer, out_load;

    // setup terms
    logic signed [CW:0]   dx, dy;
    logic        [CW-1:0] adx, ady;
    logic                 su_ma;
    logic signed [CW-1:0] su_stmaj, su_endmaj;
    logic        [LW-1:0] su_limmaj;
    logic signed [CW-1:0] su_limmaj_s;
    logic                 start_ok;

    // walk terms
    logic                 past;
    logic signed [CW:0]   e1;
    logic signed [CW-1:0] pmin_step, pmaj_step;
    logic                 min_out, hit_flag;
    logic                 rd_in_map;

    // memory
    logic [2*AW-1:0] rd_addr;
    logic            rd_en, rd_data;

    // square and root
    logic signed [8:0]  mul_op;
    logic signed [17:0] mul_res;
    logic               sq_start, sq_done;
    logic [gro_pkg::ROOT_W-1:0] sq_root;

    assign s_tready  = (state_reg == gro_pkg::S_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign wr_xfer   = s_xfer && (s_tuser == gro_pkg::ACT_WRITE);
    assign cast_xfer = s_xfer && (s_tuser == gro_pkg::ACT_CAST);
    assign out_load  = (state_reg == gro_pkg::S_DONE) && (!m_tvalid_reg || m_tready);

    // registers above the grid size saturate
    assign lim_x = (map_width_reg  > LW'(gro_pkg::MAP_DIM)) ? LW'(gro_pkg::MAP_DIM)
                                                             : map_width_reg;
    assign lim_y = (map_height_reg > LW'(gro_pkg::MAP_DIM)) ? LW'(gro_pkg::MAP_DIM)
                                                             : map_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= LW'(gro_pkg::MAP_DIM);
            map_height_reg <= LW'(gro_pkg::MAP_DIM);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gro_pkg::REG_MAP_WIDTH:  map_width_reg  <= cfg_wdata;
                gro_pkg::REG_MAP_HEIGHT: map_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // operands captured at the cast transfer
    always_ff @(posedge aclk) begin
        if (cast_xfer) begin
            sx_reg <= gro_pkg::to_cell(s_tdata[32:17]);
            sy_reg <= gro_pkg::to_cell(s_tdata[48:33]);
            ex_reg <= gro_pkg::to_cell(s_tdata[64:49]);
            ey_reg <= gro_pkg::to_cell(s_tdata[80:65]);
        end
    end

    // setup: pick the major axis, clip its end to the map
    assign dx  = {ex_reg[CW-1], ex_reg} - {sx_reg[CW-1], sx_reg};
    assign dy  = {ey_reg[CW-1], ey_reg} - {sy_reg[CW-1], sy_reg};
    assign adx = dx[CW] ? CW'(-dx) : CW'(dx);
    assign ady = dy[CW] ? CW'(-dy) : CW'(dy);
    assign su_ma       = (adx < ady);
    assign su_stmaj    = su_ma ? sy_reg : sx_reg;
    assign su_endmaj   = su_ma ? ey_reg : ex_reg;
    assign su_limmaj   = su_ma ? lim_y : lim_x;
    assign su_limmaj_s = $signed({{(CW-LW){1'b0}}, su_limmaj});
    assign start_ok = !sx_reg[CW-1] && !sy_reg[CW-1]
                   && (sx_reg < $signed({{(CW-LW){1'b0}}, lim_x}))
                   && (sy_reg < $signed({{(CW-LW){1'b0}}, lim_y}));

    // walk terms
    assign past      = negmaj_reg ? (pmaj_reg < bound_reg) : (pmaj_reg > bound_reg);
    assign e1        = err_reg - $signed({1'b0, dmin_reg});
    assign pmin_step = negmin_reg ? pmin_reg - 1'b1 : pmin_reg + 1'b1;
    assign pmaj_step = negmaj_reg ? pmaj_reg - 1'b1 : pmaj_reg + 1'b1;
    assign min_out   = pmin_step[CW-1]
                    || (pmin_step >= $signed({{(CW-LW){1'b0}}, limmin_reg}));
    assign hit_flag  = negmaj_reg ? (pmaj_reg >= endmaj_reg) : (pmaj_reg <= endmaj_reg);
    assign rd_in_map = !pmaj_reg[CW-1] && !pmin_reg[CW-1]
                    && (pmin_reg < $signed({{(CW-LW){1'b0}}, limmin_reg}));

    // grid address is x * MAP_DIM + y
    assign rd_en   = (state_reg == gro_pkg::S_CHECK);
    assign rd_addr = ma_reg ? {pmin_reg[AW-1:0], pmaj_reg[AW-1:0]}
                            : {pmaj_reg[AW-1:0], pmin_reg[AW-1:0]};

    gro_map_ram u_map (
        .aclk    (aclk),
        .wr_en   (wr_xfer),
        .wr_addr ({s_tdata[AW-1:0], s_tdata[8+AW-1:8]}),
        .wr_data (s_tdata[16]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one shared multiplier squares the major then the minor offset
    assign mul_op  = (state_reg == gro_pkg::S_SQX) ? 9'(prmaj_reg - stmaj_reg)
                                                    : 9'(prmin_reg - stmin_reg);
    assign mul_res = mul_op * mul_op;

    assign sq_start = (state_reg == gro_pkg::S_ROOT_GO);

    gro_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({1'b0, acc_reg, 8'b0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gro_pkg::S_IDLE:    if (cast_xfer) state_next = gro_pkg::S_START;
            gro_pkg::S_START:   state_next = start_ok ? gro_pkg::S_CHECK : gro_pkg::S_DONE;
            gro_pkg::S_CHECK:   state_next = past ? gro_pkg::S_HIT : gro_pkg::S_RD;
            gro_pkg::S_RD: begin
                if (!rd_data || (e1 < 0 && min_out)) begin
                    state_next = gro_pkg::S_HIT;
                end else begin
                    state_next = gro_pkg::S_CHECK;
                end
            end
            gro_pkg::S_HIT:     state_next = hit_flag ? gro_pkg::S_SQX : gro_pkg::S_DONE;
            gro_pkg::S_SQX:     state_next = gro_pkg::S_SQY;
            gro_pkg::S_SQY:     state_next = gro_pkg::S_ROOT_GO;
            gro_pkg::S_ROOT_GO: state_next = gro_pkg::S_ROOT;
            gro_pkg::S_ROOT:    if (sq_done) state_next = gro_pkg::S_DONE;
            gro_pkg::S_DONE:    if (out_load) state_next = gro_pkg::S_IDLE;
            default:            state_next = gro_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        ma_next        = ma_reg;
        negmaj_next    = negmaj_reg;
        negmin_next    = negmin_reg;
        pmaj_next      = pmaj_reg;
        pmin_next      = pmin_reg;
        prmaj_next     = prmaj_reg;
        prmin_next     = prmin_reg;
        stmaj_next     = stmaj_reg;
        stmin_next     = stmin_reg;
        endmaj_next    = endmaj_reg;
        bound_next     = bound_reg;
        dmaj_next      = dmaj_reg;
        dmin_next      = dmin_reg;
        err_next       = err_reg;
        limmin_next    = limmin_reg;
        acc_next       = acc_reg;
        res_hit_next   = res_hit_reg;
        res_range_next = res_range_reg;
        case (state_reg)
            gro_pkg::S_START: begin
                ma_next     = su_ma;
                negmaj_next = su_ma ? dy[CW] : dx[CW];
                negmin_next = su_ma ? dx[CW] : dy[CW];
                pmaj_next   = su_stmaj;
                pmin_next   = su_ma ? sx_reg : sy_reg;
                stmaj_next  = su_stmaj;
                stmin_next  = su_ma ? sx_reg : sy_reg;
                prmaj_next  = su_stmaj;
                prmin_next  = su_ma ? sx_reg : sy_reg;
                endmaj_next = su_endmaj;
                dmaj_next   = su_ma ? ady : adx;
                dmin_next   = su_ma ? adx : ady;
                limmin_next = su_ma ? lim_x : lim_y;
                err_next    = $signed({2'b00, dmaj_next[CW-1:1]});
                if (su_ma ? dy[CW] : dx[CW]) begin
                    bound_next = su_endmaj[CW-1] ? '0 : su_endmaj;
                end else begin
                    bound_next = (su_endmaj < su_limmaj_s) ? su_endmaj
                                                           : su_limmaj_s - 1'b1;
                end
                // off-map start: hit at range zero
                res_hit_next   = 1'b1;
                res_range_next = '0;
            end
            gro_pkg::S_CHECK: begin
                if (!past) begin
                    prmaj_next = pmaj_reg;
                    prmin_next = pmin_reg;
                end
            end
            gro_pkg::S_RD: begin
                if (rd_data) begin
                    if (e1 < 0) begin
                        pmin_next = pmin_step;
                        if (!min_out) begin
                            err_next  = e1 + $signed({1'b0, dmaj_reg});
                            pmaj_next = pmaj_step;
                        end
                    end else begin
                        err_next  = e1;
                        pmaj_next = pmaj_step;
                    end
                end
            end
            gro_pkg::S_HIT: begin
                res_hit_next   = 1'b0;
                res_range_next = gro_pkg::RANGE_NO_HIT;
            end
            gro_pkg::S_SQX: acc_next = mul_res[16:0];
            gro_pkg::S_SQY: acc_next = acc_reg + mul_res[16:0];
            gro_pkg::S_ROOT: begin
                res_hit_next   = 1'b1;
                res_range_next = $signed({1'b0, sq_root});
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, res_range_reg, res_hit_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gro_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ma_reg        <= ma_next;
        negmaj_reg    <= negmaj_next;
        negmin_reg    <= negmin_next;
        pmaj_reg      <= pmaj_next;
        pmin_reg      <= pmin_next;
        prmaj_reg     <= prmaj_next;
        prmin_reg     <= prmin_next;
        stmaj_reg     <= stmaj_next;
        stmin_reg     <= stmin_next;
        endmaj_reg    <= endmaj_next;
        bound_reg     <= bound_next;
        dmaj_reg      <= dmaj_next;
        dmin_reg      <= dmin_next;
        err_reg       <= err_next;
        limmin_reg    <= limmin_next;
        acc_reg       <= acc_next;
        res_hit_reg   <= res_hit_next;
        res_range_reg <= res_range_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // every grid read of the walk lands inside the map
    `GRO_ASSERT_IMPL(a_read_in_map, aclk, aresetn, rd_en && !past, rd_in_map)
    // a pending result is never overwritten
    `GRO_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, out_load, !m_tvalid_reg || m_tready)
    // the sequencer enters the root wait state once the root unit is started
    `GRO_ASSERT_NEXT(a_root_wait, aclk, aresetn, sq_start, state_reg == gro_pkg::S_ROOT)

endmodule

// ===== tb/tb_top.sv =====
// testbench for the grid ray caster: directed and random writes and casts checked by a predictor
module tb_top;

    // side of the grid corner that fill_grid writes; random casts read only written cells
    localparam int FILL = 20;

    // expected cast results, oldest first
    class cast_scoreboard;
        bit               grid [256][256];
        bit               written [256][256];
        int unsigned      width_reg;
        int unsigned      height_reg;
        logic [14:0]      pending [$];
        int               errors;

        function void clear();
            width_reg = 256;
            height_reg = 256;
            errors = 0;
            foreach (grid[i, j]) begin
                grid[i][j] = 1'b0;
                written[i][j] = 1'b0;
            end
        endfunction

        static function int cell_of(logic signed [15:0] v);
            int t;
            t = int'(v) + 8;
            return t / 16;
        endfunction

        static function longint unsigned root_of(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // walk one cast; returns whether every cell it reads was written before
        function bit predict(logic [87:0] d, output logic [14:0] res);
            int lim [2];
            int p [2];
            int st [2];
            int en [2];
            int sg [2];
            int dd [2];
            int pv [2];
            int ma, mi, bound, err;
            bit hit, free, ok;
            longint ex, ey;
            longint unsigned d2, sq, r;
            ok = 1'b1;
            lim[0] = width_reg < 256 ? width_reg : 256;
            lim[1] = height_reg < 256 ? height_reg : 256;
            st[0] = cell_of(d[32:17]);
            st[1] = cell_of(d[48:33]);
            en[0] = cell_of(d[64:49]);
            en[1] = cell_of(d[80:65]);
            if (st[0] < 0 || st[1] < 0 || st[0] >= lim[0] || st[1] >= lim[1]) begin
                res = {14'd0, 1'b1};
                return ok;
            end
            if (!written[st[0]][st[1]]) ok = 1'b0;
            if (!grid[st[0]][st[1]]) begin
                res = {14'd0, 1'b1};
                return ok;
            end
            for (int k = 0; k < 2; k++) begin
                sg[k] = (en[k] - st[k]) >= 0 ? 1 : -1;
                dd[k] = (en[k] - st[k]) * sg[k];
                p[k] = st[k];
                pv[k] = st[k];
            end
            ma = dd[0] >= dd[1] ? 0 : 1;
            mi = 1 - ma;
            if (sg[ma] > 0) bound = en[ma] < lim[ma] ? en[ma] : lim[ma] - 1;
            else bound = en[ma] < 0 ? 0 : en[ma];
            err = dd[ma] >>> 1;
            forever begin
                if (sg[ma] > 0 ? p[ma] > bound : p[ma] < bound) break;
                pv[0] = p[0];
                pv[1] = p[1];
                if (!written[p[0]][p[1]]) ok = 1'b0;
                free = grid[p[0]][p[1]];
                if (!free) break;
                err -= dd[mi];
                if (err < 0) begin
                    p[mi] += sg[mi];
                    if (p[mi] < 0 || p[mi] >= lim[mi]) break;
                    err += dd[ma];
                end
                p[ma] += sg[ma];
            end
            hit = sg[ma] > 0 ? p[ma] <= en[ma] : p[ma] >= en[ma];
            if (!hit) begin
                res = {gro_pkg::RANGE_NO_HIT, 1'b0};
                return ok;
            end
            ex = pv[0] - st[0];
            ey = pv[1] - st[1];
            d2 = longint'(ex * ex + ey * ey) * 256;
            sq = root_of(d2);
            r = (d2 - sq * sq > sq) ? sq + 1 : sq;
            if (r > 8191) r = 8191;
            res = {r[13:0], 1'b1};
            return ok;
        endfunction

        // note an accepted input transfer; a cast queues its result
        function void note_input(logic act, logic [87:0] d);
            logic [14:0] e;
            if (act == gro_pkg::ACT_WRITE) begin
                grid[d[7:0]][d[15:8]] = d[16];
                written[d[7:0]][d[15:8]] = 1'b1;
                return;
            end
            void'(predict(d, e));
            pending.push_back(e);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(logic [15:0] d);
            logic [14:0] e;
            if (pending.size() == 0) begin
                $error("unexpected result hit=%0d range=%0d", d[0], $signed(d[14:1]));
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e[0]) begin
                $error("hit expected %0d actual %0d", e[0], d[0]);
                errors++;
            end
            if (d[14:1] !== e[14:1]) begin
                $error("range_q4 expected %0d actual %0d", $signed(e[14:1]),
                       $signed(d[14:1]));
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // cell_x, cell_y, cell_value, start_x, start_y, end_x, end_y, zero fill
    logic [87:0] s_tdata;
    // action
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // hit, range_q4, zero fill
    logic [15:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [8:0]  cfg_wdata;

    cast_scoreboard sb;
    int          hold_cycles;   // long receiver hold-off when nonzero
    int          burst_left;
    bit          bursty;        // whether the sender gaps at all

    grid_ray_obstacle_cast u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: stalls on its own pattern, with a counted long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                case ($urandom_range(0, 3))
                    0: m_tready <= 1'b0;
                    1: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // random ray coordinate: mostly on the map, sometimes anywhere in range
    function automatic logic [15:0] coord(int lim);
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($urandom_range(0, lim * 16 + 24)) - 16'd8;
    endfunction

    // offer one item and wait for its transfer; gaps fall between bursts
    task automatic send(logic act, logic [87:0] d);
        if (bursty && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(act, d);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic idle_out();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        // casts done and checked
        repeat (600) @(posedge aclk);
    endtask

    task automatic set_reg(logic idx, logic [8:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == gro_pkg::REG_MAP_WIDTH) sb.width_reg = v;
        else sb.height_reg = v;
    endtask

    function automatic logic [87:0] wr_item(int x, int y, bit v);
        return {7'd0, 64'd0, 1'(v), 8'(y), 8'(x)};
    endfunction

    function automatic logic [87:0] cast_item(logic [15:0] sx, logic [15:0] sy,
                                              logic [15:0] ex, logic [15:0] ey);
        return {7'd0, ey, ex, sy, sx, 17'($urandom())};
    endfunction

    task automatic fill_grid(int pct_free);
        for (int x = 0; x < FILL; x++)
            for (int y = 0; y < FILL; y++)
                send(gro_pkg::ACT_WRITE, wr_item(x, y, $urandom_range(0, 99) < pct_free));
    endtask

    // casts that would read an unwritten cell are redrawn, else (and one time in five) a write goes out
    task automatic random_casts(int n, int wlim, int hlim);
        int lim;
        bit safe;
        logic [87:0] d;
        logic [14:0] e;
        lim = wlim > hlim ? wlim : hlim;
        for (int i = 0; i < n; i++) begin
            safe = 1'b0;
            if ($urandom_range(0, 4) != 0) begin
                for (int t = 0; t < 50 && !safe; t++) begin
                    d = cast_item(coord(wlim), coord(hlim), coord(lim), coord(lim));
                    safe = sb.predict(d, e);
                end
            end
            if (safe)
                send(gro_pkg::ACT_CAST, d);
            else
                send(gro_pkg::ACT_WRITE, wr_item($urandom_range(0, 255),
                                                 $urandom_range(0, 255),
                                                 $urandom_range(0, 1)));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        hold_cycles = 0;
        burst_left = 0;
        bursty = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = gro_pkg::ACT_WRITE;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = gro_pkg::REG_MAP_WIDTH;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // the written corner covers every cell that a cast may read
        fill_grid(100);
        idle_out();
        set_reg(gro_pkg::REG_MAP_WIDTH, 9'(FILL));
        set_reg(gro_pkg::REG_MAP_HEIGHT, 9'(FILL));
        // directed casts on an all-free grid
        send(gro_pkg::ACT_CAST, cast_item(16'sd8, 16'sd8, 16'sd4000, 16'sd8));  // leave map
        send(gro_pkg::ACT_CAST, cast_item(16'sd16, 16'sd16, 16'sd160, 16'sd96)); // no hit
        send(gro_pkg::ACT_CAST, cast_item(16'sd4080, 16'sd4080, -16'sd32768, -16'sd32768));
        send(gro_pkg::ACT_CAST, cast_item(-16'sd9, 16'sd0, 16'sd0, 16'sd0));    // start -9 rounds to cell zero
        send(gro_pkg::ACT_CAST, cast_item(16'sd32767, 16'sd0, 16'sd0, 16'sd0));
        send(gro_pkg::ACT_CAST, cast_item(16'sd100, 16'sd100, 16'sd100, 16'sd100)); // zero length
        send(gro_pkg::ACT_CAST, cast_item(16'sd0, 16'sd0, 16'sd4080, 16'sd4080)); // long diagonal
        send(gro_pkg::ACT_CAST, cast_item(16'sd0, 16'sd4080, 16'sd4080, -16'sd200));
        // obstacle in the path, then an obstacle at the start
        send(gro_pkg::ACT_WRITE, wr_item(10, 2, 0));
        send(gro_pkg::ACT_CAST, cast_item(16'sd32, 16'sd32, 16'sd400, 16'sd32));
        send(gro_pkg::ACT_CAST, cast_item(16'sd160, 16'sd32, 16'sd160, 16'sd32));
        send(gro_pkg::ACT_WRITE, wr_item(10, 2, 1));
        send(gro_pkg::ACT_CAST, cast_item(16'sd7, -16'sd8, 16'sd300, 16'sd7));
        idle_out();

        // tiny map, extremes of the registers including zero and oversize
        set_reg(gro_pkg::REG_MAP_WIDTH, 9'd1);
        set_reg(gro_pkg::REG_MAP_HEIGHT, 9'd1);
        send(gro_pkg::ACT_CAST, cast_item(16'sd0, 16'sd0, 16'sd200, 16'sd200));
        send(gro_pkg::ACT_CAST, cast_item(16'sd16, 16'sd0, 16'sd0, 16'sd0));
        idle_out();
        set_reg(gro_pkg::REG_MAP_WIDTH, 9'd0);
        set_reg(gro_pkg::REG_MAP_HEIGHT, 9'd511);
        send(gro_pkg::ACT_CAST, cast_item(16'sd0, 16'sd0, 16'sd200, 16'sd200));
        idle_out();

        bursty = 1'b1;
        // random phases with varied grids and map sizes
        for (int ph = 0; ph < 6; ph++) begin
            int w, h;
            w = (ph == 0) ? 256 : (ph == 1) ? 511 : $urandom_range(1, 64);
            h = (ph == 2) ? 256 : $urandom_range(1, 300);
            set_reg(gro_pkg::REG_MAP_WIDTH, 9'(w));
            set_reg(gro_pkg::REG_MAP_HEIGHT, 9'(h));
            if (w > FILL) w = FILL;
            if (h > FILL) h = FILL;
            if (ph == 3) fill_grid(90);
            if (ph == 4) begin
                // receiver holds off long while the sender keeps offering
                bursty = 1'b0;
                hold_cycles = 3000;
            end
            random_casts(40, w, h);
            bursty = 1'b1;
            idle_out();
        end
        set_reg(gro_pkg::REG_MAP_WIDTH, 9'd256);
        set_reg(gro_pkg::REG_MAP_HEIGHT, 9'd256);
        random_casts(50, FILL, FILL);
        idle_out();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
